/* src/mpbk_pkg.sv */
package mpbk_pkg;

   // Fixed field widths of the ports
   localparam int KIND_W     = 2;
   localparam int SYM_W      = 4;
   localparam int WORD_W     = 64;
   localparam int END_BIT_W  = 6;
   localparam int ERR_W      = 3;
   localparam int POS_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int EOS_W      = 4;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BITS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ERRORS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INDELS_EN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EOS_SYMBOL = 3'd4;

   // Controls for the shared level update unit
   typedef struct packed {
      logic first;   // level 0: plain shift-and
      logic eos;     // end-of-sequence symbol: no error transitions
      logic ind;     // insertions and deletions enabled
   } lvl_ctl_type;

   // Controls from the sequencer to the hit unit
   typedef struct packed {
      logic upd;     // a new level vector is on the bus
      logic first;   // it is level 0
      logic top;     // it is the top level: latch hits
   } hit_ctl_type;

endpackage

/* src/mpbk_level_unit.sv */
module mpbk_level_unit #(
   parameter int PATTERN_BITS = 64
) (
   input  mpbk_pkg::lvl_ctl_type    ctl,
   input  logic [PATTERN_BITS-1:0]  old_vec,
   input  logic [PATTERN_BITS-1:0]  prev_vec,
   input  logic [PATTERN_BITS-1:0]  d_in,
   input  logic [PATTERN_BITS-1:0]  match_mask,
   input  logic [PATTERN_BITS-1:0]  start_bits,
   output logic [PATTERN_BITS-1:0]  new_vec,
   output logic [PATTERN_BITS-1:0]  d_out
);
   import mpbk_pkg::*;

   logic [PATTERN_BITS-1:0] shifted;
   logic [PATTERN_BITS-1:0] lower_shifted;

   assign shifted       = (old_vec << 1) | start_bits;
   assign lower_shifted = (prev_vec << 1) | start_bits;

   // Shift-and, plus substitution and optional indel terms above level 0, except on the end-of-sequence symbol
   always_comb begin
      new_vec = shifted & match_mask;
      if (!ctl.first && !ctl.eos) begin
         new_vec = new_vec | d_in;
         if (ctl.ind) begin
            new_vec = new_vec | lower_shifted | prev_vec;
         end
      end
   end

   // Carry term for the next level
   assign d_out = ctl.ind ? (shifted | old_vec) : shifted;

endmodule

/* src/mpbk_hit_unit.sv */
module mpbk_hit_unit #(
   parameter int PATTERN_BITS = 64,
   parameter int LVL_AW       = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mpbk_pkg::hit_ctl_type               ctl,
   input  logic [LVL_AW-1:0]                   lvl_idx,
   input  logic [PATTERN_BITS-1:0]             lvl_vec,
   input  logic [PATTERN_BITS-1:0]             end_bits,
   output logic                                hits_empty,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mpbk_pkg::END_BIT_W-1:0]      rsp_end_bit,
   output logic [mpbk_pkg::ERR_W-1:0]          rsp_error_count,
   output logic                                rsp_last
);
   import mpbk_pkg::*;

   logic [PATTERN_BITS-1:0]             hits_ff;
   logic [PATTERN_BITS-1:0]             run_ff;
   logic [LVL_AW-1:0][PATTERN_BITS-1:0] kplane_ff;
   logic [PATTERN_BITS-1:0]             run_prev;
   logic [PATTERN_BITS-1:0]             run_start;
   logic [PATTERN_BITS-1:0]             lowest;
   logic [END_BIT_W-1:0]                bit_idx;
   logic [LVL_AW-1:0]                   err_lvl;
   logic                                beat;

   // A run of set levels starts where the bit is set and the level below was not
   assign run_prev  = ctl.first ? '0 : run_ff;
   assign run_start = lvl_vec & ~run_prev;

   // Lowest pending hit, as a one-hot word
   assign lowest = hits_ff & (~hits_ff + PATTERN_BITS'(1));

   always_comb begin
      bit_idx = '0;
      for (int b = 0; b < PATTERN_BITS; b++) begin
         if (lowest[b]) begin
            bit_idx = bit_idx | END_BIT_W'(b);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < LVL_AW; j++) begin
         err_lvl[j] = |(kplane_ff[j] & lowest);
      end
   end

   assign hits_empty      = (hits_ff == '0);
   assign rsp_valid       = !hits_empty;
   assign rsp_end_bit     = bit_idx;
   assign rsp_error_count = ERR_W'(err_lvl);
   assign rsp_last        = ((hits_ff & (hits_ff - PATTERN_BITS'(1))) == '0);
   assign beat            = rsp_valid && rsp_ready;

   // Hit vector and level run tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= '0;
         run_ff  <= '0;
      end else begin
         if (ctl.upd) begin
            run_ff <= lvl_vec;
         end
         if (ctl.upd && ctl.top) begin
            hits_ff <= lvl_vec & end_bits;
         end else if (beat) begin
            hits_ff <= hits_ff & ~lowest;
         end
      end
   end

   // Least error level per bit, one bit plane per level index bit
   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         for (int j = 0; j < LVL_AW; j++) begin
            kplane_ff[j] <= (kplane_ff[j] & ~run_start) | (lvl_idx[j] ? run_start : '0);
         end
      end
   end

endmodule

/* src/multi_pattern_bitap_k_errors.sv */
// Packed multi-pattern approximate matcher (shift-and with up to max_errors
// errors). Registers must be written through the csr_ port only while the
// block is idle; the block itself does not enforce this. A restart writes
// every level vector in turn. A text symbol updates levels 0 to K, where
// K = min(max_errors, MAX_LEVELS-1): one shared level update unit and a level
// memory with one write and one read port handle one level vector per cycle,
// then hits leave one beat per cycle while rsp_ready is high, in ascending
// end-bit order. rsp_last marks the final hit of a symbol; a symbol with no
// hit gives no beat. req_ready is low while an item is in progress.
module multi_pattern_bitap_k_errors #(
   parameter int PATTERN_BITS  = 64,
   parameter int ALPHABET_SIZE = 16,
   parameter int MAX_LEVELS    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mpbk_pkg::KIND_W-1:0]         req_kind,
   input  logic [mpbk_pkg::SYM_W-1:0]          req_symbol,
   input  logic [mpbk_pkg::WORD_W-1:0]         req_mask_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mpbk_pkg::END_BIT_W-1:0]      rsp_end_bit,
   output logic [mpbk_pkg::ERR_W-1:0]          rsp_error_count,
   output logic [mpbk_pkg::POS_W-1:0]          rsp_text_position,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [mpbk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mpbk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mpbk_pkg::*;

   localparam int SymAw  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int LvlAw  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int TopLim = MAX_LEVELS - 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RESTART, ST_TEXT, ST_EMIT} state_type;

   state_type               state_ff;
   logic [LvlAw-1:0]        lvl_ff;
   logic [POS_W-1:0]        pos_ff;
   logic                    eos_hit_ff;
   logic [PATTERN_BITS-1:0] prev_ff;
   logic [PATTERN_BITS-1:0] d_ff;
   logic [PATTERN_BITS-1:0] acc_ff;
   logic [PATTERN_BITS-1:0] v_ff;

   // Control registers
   logic [PATTERN_BITS-1:0] start_ff;
   logic [PATTERN_BITS-1:0] end_ff;
   logic [ERR_W-1:0]        max_err_ff;
   logic                    indel_ff;
   logic [EOS_W-1:0]        eos_ff;

   // Symbol mask memory
   logic [PATTERN_BITS-1:0] mask_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] mask_vld_ff;
   logic [PATTERN_BITS-1:0] mask_rd_ff;
   logic                    mask_rd_ok_ff;

   // Level vector memory
   logic [PATTERN_BITS-1:0] lvl_mem [MAX_LEVELS];
   logic [MAX_LEVELS-1:0]   lvl_vld_ff;
   logic [PATTERN_BITS-1:0] lvl_rd_ff;
   logic                    lvl_rd_vld_ff;

   logic                    accept;
   logic                    sym_ok;
   logic [SymAw-1:0]        sym_addr;
   logic                    mask_we;
   logic                    text_start;
   logic [LvlAw-1:0]        k_top;
   logic                    at_top;
   logic                    lvl_rd_en;
   logic [LvlAw-1:0]        lvl_rd_addr;
   logic                    lvl_we;
   logic [PATTERN_BITS-1:0] lvl_wdata;
   logic [PATTERN_BITS-1:0] old_vec;
   logic [PATTERN_BITS-1:0] match_mask;
   logic [PATTERN_BITS-1:0] new_vec;
   logic [PATTERN_BITS-1:0] d_next;
   lvl_ctl_type             lvl_ctl;
   hit_ctl_type             hit_ctl;
   logic                    hits_empty;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign sym_ok     = (int'(req_symbol) < ALPHABET_SIZE);
   assign sym_addr   = SymAw'(req_symbol);
   assign mask_we    = accept && (req_kind == KIND_LOAD) && sym_ok;
   assign text_start = accept && (req_kind == KIND_TEXT);

   // Top level in use, capped at the last level
   assign k_top  = (int'(max_err_ff) > TopLim) ? LvlAw'(TopLim) : LvlAw'(max_err_ff);
   assign at_top = (lvl_ff == k_top);

   assign old_vec    = lvl_rd_vld_ff ? lvl_rd_ff : '0;
   assign match_mask = mask_rd_ok_ff ? mask_rd_ff : '0;

   // Prefetch the next level while the current one is updated
   assign lvl_rd_en   = text_start || ((state_ff == ST_TEXT) && !at_top);
   assign lvl_rd_addr = (state_ff == ST_TEXT) ? (lvl_ff + LvlAw'(1)) : '0;
   assign lvl_we      = (state_ff == ST_TEXT) || (state_ff == ST_RESTART);
   assign lvl_wdata   = (state_ff == ST_TEXT) ? new_vec : acc_ff;

   assign lvl_ctl.first = (lvl_ff == '0);
   assign lvl_ctl.eos   = eos_hit_ff;
   assign lvl_ctl.ind   = indel_ff;

   assign hit_ctl.upd   = (state_ff == ST_TEXT);
   assign hit_ctl.first = (lvl_ff == '0);
   assign hit_ctl.top   = at_top;

   assign rsp_text_position = pos_ff;

   mpbk_level_unit #(
      .PATTERN_BITS (PATTERN_BITS)
   ) u_level (
      .ctl        (lvl_ctl),
      .old_vec    (old_vec),
      .prev_vec   (prev_ff),
      .d_in       (d_ff),
      .match_mask (match_mask),
      .start_bits (start_ff),
      .new_vec    (new_vec),
      .d_out      (d_next)
   );

   mpbk_hit_unit #(
      .PATTERN_BITS (PATTERN_BITS),
      .LVL_AW       (LvlAw)
   ) u_hits (
      .clock           (clock),
      .reset           (reset),
      .ctl             (hit_ctl),
      .lvl_idx         (lvl_ff),
      .lvl_vec         (new_vec),
      .end_bits        (end_ff),
      .hits_empty      (hits_empty),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_end_bit     (rsp_end_bit),
      .rsp_error_count (rsp_error_count),
      .rsp_last        (rsp_last)
   );

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_ff     <= '0;
         max_err_ff <= '0;
         indel_ff   <= 1'b0;
         eos_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_BITS: start_ff   <= csr_wdata[PATTERN_BITS-1:0];
            CSR_END_BITS:   end_ff     <= csr_wdata[PATTERN_BITS-1:0];
            CSR_MAX_ERRORS: max_err_ff <= csr_wdata[ERR_W-1:0];
            CSR_INDELS_EN:  indel_ff   <= csr_wdata[0];
            CSR_EOS_SYMBOL: eos_ff     <= csr_wdata[EOS_W-1:0];
            default: ;
         endcase
      end
   end

   // Valid bits of both memories
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_vld_ff   <= '0;
         mask_rd_ok_ff <= 1'b0;
         lvl_vld_ff    <= '0;
         lvl_rd_vld_ff <= 1'b0;
      end else begin
         if (mask_we) begin
            mask_vld_ff[sym_addr] <= 1'b1;
         end
         if (text_start) begin
            mask_rd_ok_ff <= sym_ok ? mask_vld_ff[sym_addr] : 1'b0;
         end
         if (lvl_we) begin
            lvl_vld_ff[lvl_ff] <= 1'b1;
         end
         if (lvl_rd_en) begin
            lvl_rd_vld_ff <= lvl_vld_ff[lvl_rd_addr];
         end
      end
   end

   // Symbol mask memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[sym_addr] <= req_mask_word[PATTERN_BITS-1:0];
      end
      if (text_start && sym_ok) begin
         mask_rd_ff <= mask_mem[sym_addr];
      end
   end

   // Level vector memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_ff] <= lvl_wdata;
      end
      if (lvl_rd_en) begin
         lvl_rd_ff <= lvl_mem[lvl_rd_addr];
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         lvl_ff     <= '0;
         pos_ff     <= '0;
         eos_hit_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_kind)
                     KIND_TEXT: begin
                        state_ff   <= ST_TEXT;
                        lvl_ff     <= '0;
                        eos_hit_ff <= (req_symbol == eos_ff);
                     end
                     KIND_RESTART: begin
                        state_ff <= ST_RESTART;
                        lvl_ff   <= '0;
                        acc_ff   <= '0;
                        v_ff     <= start_ff;
                     end
                     KIND_LOAD: ;
                     default: ;
                  endcase
               end
            end
            ST_RESTART: begin
               // Level l holds the first l positions of each pattern
               acc_ff <= acc_ff | v_ff;
               v_ff   <= (v_ff & ~end_ff) << 1;
               if (lvl_ff == LvlAw'(TopLim)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  lvl_ff <= lvl_ff + LvlAw'(1);
               end
            end
            ST_TEXT: begin
               prev_ff <= new_vec;
               d_ff    <= d_next;
               if (at_top) begin
                  state_ff <= ST_EMIT;
               end else begin
                  lvl_ff <= lvl_ff + LvlAw'(1);
               end
            end
            ST_EMIT: begin
               if (hits_empty) begin
                  pos_ff   <= pos_ff + POS_W'(1);
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

/* src/mpbk_checker.sv */
module mpbk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mpbk_pkg::END_BIT_W-1:0]      rsp_end_bit,
   input logic [mpbk_pkg::POS_W-1:0]          rsp_text_position,
   input logic                                rsp_last
);

   // No new item is taken while hits are still going out
   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while hits pending");

   // After the final hit beat of a symbol the result side goes quiet
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("hit beat after last");

   // Hits of one symbol follow back to back at the same text position
   a_same_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_text_position))
      else $error("hit group broken or position changed");

   // Hits of one symbol come in ascending end-bit order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_end_bit > $past(rsp_end_bit))
      else $error("hits out of order");

endmodule

bind multi_pattern_bitap_k_errors mpbk_checker u_mpbk_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import mpbk_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int LEVELS        = 8;
   localparam int SYMBOLS       = 16;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [END_BIT_W-1:0] end_bit;
      logic [ERR_W-1:0]     error_count;
      logic [POS_W-1:0]     text_position;
      logic                 last;
   } hit_rec_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind;
   logic [SYM_W-1:0]      req_symbol;
   logic [WORD_W-1:0]     req_mask_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [END_BIT_W-1:0]  rsp_end_bit;
   logic [ERR_W-1:0]      rsp_error_count;
   logic [POS_W-1:0]      rsp_text_position;
   logic                  rsp_last;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // matcher state as predicted
   logic [WORD_W-1:0] sym_mask [SYMBOLS];
   logic [WORD_W-1:0] lvl_vec [LEVELS];
   logic [POS_W-1:0]  text_pos;
   logic [WORD_W-1:0] cfg_start;
   logic [WORD_W-1:0] cfg_end;
   logic [ERR_W-1:0]  cfg_max_err;
   logic              cfg_indels;
   logic [EOS_W-1:0]  cfg_eos;

   hit_rec_type hit_q [$];
   int          mismatch_count = 0;
   bit          idle_on = 1'b1;

   multi_pattern_bitap_k_errors i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_symbol        (req_symbol),
      .req_mask_word     (req_mask_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_end_bit       (rsp_end_bit),
      .rsp_error_count   (rsp_error_count),
      .rsp_text_position (rsp_text_position),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict the effect of one accepted item; text steps queue their hits
   function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] u, d, old, sh, lo, hits, v, acc;
      int top, k;
      hit_rec_type h;
      case (kind)
         KIND_LOAD: begin
            sym_mask[sym] = word;
         end
         KIND_RESTART: begin
            // level l: start bits walked 0..l-1 steps, never past an end bit
            for (int l = 0; l < LEVELS; l++) begin
               v = cfg_start;
               acc = '0;
               for (int j = 0; j < l; j++) begin
                  acc |= v;
                  v = (v & ~cfg_end) << 1;
               end
               lvl_vec[l] = acc;
            end
         end
         KIND_TEXT: begin
            u = sym_mask[sym];
            top = (int'(cfg_max_err) > LEVELS - 1) ? LEVELS - 1 : int'(cfg_max_err);
            old = lvl_vec[0];
            d = (old << 1) | cfg_start;
            lvl_vec[0] = d & u;
            if (cfg_indels) d |= old;
            for (int l = 1; l <= top; l++) begin
               old = lvl_vec[l];
               sh = (old << 1) | cfg_start;
               lvl_vec[l] = sh & u;
               // error transitions are blocked on the end-of-sequence code
               if (sym != cfg_eos) begin
                  lo = lvl_vec[l-1];
                  lvl_vec[l] |= d;
                  if (cfg_indels) lvl_vec[l] |= ((lo << 1) | cfg_start) | lo;
                  d = sh | (cfg_indels ? old : '0);
               end
            end
            hits = lvl_vec[top] & cfg_end;
            for (int b = 0; b < WORD_W; b++) begin
               if (hits[b]) begin
                  k = top;
                  while (k > 0 && lvl_vec[k-1][b]) k--;
                  h.end_bit = END_BIT_W'(b);
                  h.error_count = ERR_W'(k);
                  h.text_position = text_pos;
                  h.last = ((hits >> b) == 64'd1);
                  hit_q.insert(hit_q.size(), h);
               end
            end
            text_pos++;
         end
         default: begin
         end
      endcase
   endfunction

   // Result side: random stall bursts while idling is on
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each hit beat with the oldest expectation
   always @(posedge clock) begin : hit_check
      hit_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_q.size() == 0) begin
            $error("unexpected hit beat: end_bit %0d error_count %0d text_position %0d",
                   rsp_end_bit, rsp_error_count, rsp_text_position);
            mismatch_count++;
         end else begin
            want = hit_q.pop_front();
            if (rsp_end_bit !== want.end_bit) begin
               $error("end_bit: expected %0d, got %0d", want.end_bit, rsp_end_bit);
               mismatch_count++;
            end
            if (rsp_error_count !== want.error_count) begin
               $error("error_count: expected %0d, got %0d",
                      want.error_count, rsp_error_count);
               mismatch_count++;
            end
            if (rsp_text_position !== want.text_position) begin
               $error("text_position: expected %0d, got %0d",
                      want.text_position, rsp_text_position);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Send one request beat and predict it once accepted
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                            input logic [WORD_W-1:0] word);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_symbol    <= sym;
      req_mask_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(kind, sym, word);
   endtask

   // Drop valid, wait for all hits, then let the block finish any silent item
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hit_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_START_BITS: cfg_start = data;
         CSR_END_BITS:   cfg_end = data;
         CSR_MAX_ERRORS: cfg_max_err = data[ERR_W-1:0];
         CSR_INDELS_EN:  cfg_indels = data[0];
         CSR_EOS_SYMBOL: cfg_eos = data[EOS_W-1:0];
         default: ;
      endcase
   endtask

   // Write all registers; junk sets the unused upper data bits at random
   task automatic set_config(input logic [WORD_W-1:0] start_v, input logic [WORD_W-1:0] end_v,
                             input logic [ERR_W-1:0] max_e, input logic ind,
                             input logic [EOS_W-1:0] eos, input bit junk);
      logic [CSR_DATA_W-1:0] hi;
      hi = junk ? {$urandom, $urandom} : '0;
      write_reg(CSR_START_BITS, start_v);
      write_reg(CSR_END_BITS, end_v);
      write_reg(CSR_MAX_ERRORS, {hi[CSR_DATA_W-1:ERR_W], max_e});
      write_reg(CSR_INDELS_EN, {hi[CSR_DATA_W-1:1], ind});
      write_reg(CSR_EOS_SYMBOL, {hi[CSR_DATA_W-1:EOS_W], eos});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One phase: random packed patterns, masks, restart and mutated text
   task automatic run_phase(input int n_text);
      logic [SYM_W-1:0]  pat_char [WORD_W];
      int                pat_first [WORD_W];
      int                pat_len [WORD_W];
      logic [WORD_W-1:0] start_v, end_v, in_pat, m;
      int                pat_n, pos, len, n_sent, sel, p, r;
      bit                scramble;
      start_v = '0;
      end_v = '0;
      in_pat = '0;
      pat_n = 0;
      pos = 0;
      for (int i = 0; i < WORD_W; i++) pat_char[i] = SYM_W'($urandom_range(0, SYMBOLS - 1));
      while (pos < WORD_W) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : $urandom_range(3, 8);
         if (pos + len > WORD_W) len = WORD_W - pos;
         start_v[pos] = 1'b1;
         end_v[pos + len - 1] = 1'b1;
         for (int i = pos; i < pos + len; i++) in_pat[i] = 1'b1;
         pat_first[pat_n] = pos;
         pat_len[pat_n] = len;
         pat_n++;
         pos += len + $urandom_range(0, 3);
      end
      scramble = ($urandom_range(0, 4) == 0);
      if (scramble) begin
         start_v = {$urandom, $urandom};
         end_v = {$urandom, $urandom};
      end
      set_config(start_v, end_v, ERR_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 EOS_W'($urandom_range(0, SYMBOLS - 1)), 1'($urandom_range(0, 1)));

      for (int s = 0; s < SYMBOLS; s++) begin
         m = '0;
         for (int i = 0; i < WORD_W; i++)
            if (in_pat[i] && pat_char[i] == s) m[i] = 1'b1;
         if (scramble)
            m = {$urandom, $urandom};
         else if ($urandom_range(0, 5) == 0)
            m |= {$urandom, $urandom} & {$urandom, $urandom};
         send_item(KIND_LOAD, SYM_W'(s), m);
      end
      send_item(KIND_RESTART, SYM_W'($urandom), {$urandom, $urandom});

      n_sent = 0;
      while (n_sent < n_text) begin
         sel = $urandom_range(0, 99);
         if (sel < 4) begin
            send_item(KIND_RESTART, SYM_W'($urandom), {$urandom, $urandom});
         end else if (sel < 6) begin
            send_item(KIND_LOAD, SYM_W'($urandom), {$urandom, $urandom});
         end else if (sel < 8) begin
            send_item(KIND_UNUSED, SYM_W'($urandom), {$urandom, $urandom});
         end else if (sel < 22) begin
            send_item(KIND_TEXT,
                      (sel < 12) ? cfg_eos : SYM_W'($urandom_range(0, SYMBOLS - 1)),
                      {$urandom, $urandom});
            n_sent++;
         end else begin
            // one pattern copy with substitutions, deletions and insertions
            p = $urandom_range(0, pat_n - 1);
            for (int i = 0; i < pat_len[p]; i++) begin
               r = $urandom_range(0, 99);
               if (r < 6) begin
                  send_item(KIND_TEXT, SYM_W'($urandom), {$urandom, $urandom});
                  n_sent++;
               end else if (r >= 10) begin
                  if (r < 14) begin
                     send_item(KIND_TEXT, SYM_W'($urandom), {$urandom, $urandom});
                     n_sent++;
                  end
                  send_item(KIND_TEXT, pat_char[pat_first[p] + i], {$urandom, $urandom});
                  n_sent++;
               end
            end
         end
      end
      settle_block();
   endtask

   // Text and unused kinds straight after reset: nothing matches
   task automatic test_reset_state();
      send_item(KIND_TEXT, 4'd0, '0);
      send_item(KIND_UNUSED, 4'd15, '1);
      send_item(KIND_TEXT, 4'd15, '1);
      settle_block();
   endtask

   // Every bit a one-symbol pattern: up to 64 hits for one symbol
   task automatic test_single_position_patterns();
      set_config('1, '1, 3'd0, 1'b0, 4'd0, 1'b0);
      send_item(KIND_LOAD, 4'd5, '1);
      send_item(KIND_LOAD, 4'd10, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(KIND_LOAD, 4'd0, '0);
      send_item(KIND_TEXT, 4'd5, '0);
      send_item(KIND_TEXT, 4'd10, '1);
      send_item(KIND_TEXT, 4'd0, '0);
      settle_block();
   endtask

   // Two short patterns at both word ends, all levels, indels, end-of-sequence
   task automatic test_error_levels();
      set_config(64'h1000_0000_0000_0001, 64'h8000_0000_0000_0008, 3'd7, 1'b1, 4'd15, 1'b0);
      send_item(KIND_LOAD, 4'd1, 64'h8000_0000_0000_0001);
      send_item(KIND_LOAD, 4'd2, 64'h4000_0000_0000_0002);
      send_item(KIND_LOAD, 4'd3, 64'h2000_0000_0000_0004);
      send_item(KIND_LOAD, 4'd4, 64'h1000_0000_0000_0008);
      send_item(KIND_RESTART, 4'd0, '0);
      send_item(KIND_TEXT, 4'd1, '0);
      send_item(KIND_TEXT, 4'd2, '0);
      send_item(KIND_TEXT, 4'd9, '0);
      send_item(KIND_TEXT, 4'd4, '0);
      send_item(KIND_TEXT, 4'd15, '0);
      send_item(KIND_TEXT, 4'd4, '0);
      send_item(KIND_TEXT, 4'd3, '0);
      send_item(KIND_TEXT, 4'd2, '0);
      send_item(KIND_TEXT, 4'd1, '0);
      settle_block();
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < 5; ph++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         run_phase(40);
      end
   endtask

   task automatic test_no_stall_tail();
      idle_on = 1'b0;
      run_phase(30);
   endtask

   initial begin : main_seq
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_TEXT;
      req_symbol    = '0;
      req_mask_word = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_START_BITS;
      csr_wdata     = '0;
      for (int s = 0; s < SYMBOLS; s++) sym_mask[s] = '0;
      for (int l = 0; l < LEVELS; l++) lvl_vec[l] = '0;
      text_pos    = '0;
      cfg_start   = '0;
      cfg_end     = '0;
      cfg_max_err = '0;
      cfg_indels  = 1'b0;
      cfg_eos     = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_single_position_patterns();
      test_error_levels();
      test_random_traffic();
      test_no_stall_tail();

      if (hit_q.size() != 0) begin
         $error("%0d expected hits never arrived", hit_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
